[hw/rtl/gta_pkg.sv]
package gta_pkg;

  localparam int NUM_ENTRIES  = 2048;
  localparam int NUM_RESERVED = 8;
  localparam int REF_W        = 11;
  localparam int FLAGS_W      = 4;
  localparam int FRAME_W      = 32;
  localparam int DOM_W        = 16;

  localparam logic [1:0] REQ_GRANT = 2'd0;
  localparam logic [1:0] REQ_END   = 2'd1;
  localparam logic [1:0] REQ_PEER  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BUSY   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADREF = 2'd3;

  localparam int FL_PERMIT  = 0;
  localparam int FL_RDONLY  = 1;
  localparam int FL_READING = 2;
  localparam int FL_WRITING = 3;

  typedef struct packed {
    logic init_wr;
    logic load;
    logic exec;
  } gta_cmd_t;

  typedef struct packed {
    logic sweep_done;
  } gta_stat_t;

endpackage

[hw/rtl/gta_ctrl.sv]
module gta_ctrl import gta_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  gta_stat_t stat,
  output gta_cmd_t  cmd
);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.init_wr  = 1'b0;
    cmd.load     = 1'b0;
    cmd.exec     = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.sweep_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $past(cmd.load))
    else $error("Execution step without a preceding transfer.");

  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("Accepted item was not executed in the next cycle.");

  a_no_load_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init_wr |-> !cmd.load && busy)
    else $error("Transfer accepted during the clearing pass.");

endmodule

[hw/rtl/gta_dp.sv]
module gta_dp import gta_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  gta_cmd_t           cmd,
  output gta_stat_t          stat,
  input  logic [1:0]         in_req_type,
  input  logic [DOM_W-1:0]   in_domain_id,
  input  logic [FRAME_W-1:0] in_frame,
  input  logic               in_read_only,
  input  logic [REF_W-1:0]   in_ref_req,
  input  logic               in_peer_reading,
  input  logic               in_peer_writing,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [REF_W-1:0]   out_granted_ref
);

  logic [REF_W-1:0]         next_free_mem [NUM_ENTRIES];
  logic [FLAGS_W-1:0]       flags_mem     [NUM_ENTRIES];
  logic [DOM_W+FRAME_W-1:0] entry_mem     [NUM_ENTRIES];

  logic [REF_W-1:0]   sweep_r;
  logic [REF_W-1:0]   head_r;
  logic [REF_W-1:0]   head_nxt;
  logic [1:0]         req_r;
  logic [DOM_W-1:0]   dom_r;
  logic [FRAME_W-1:0] frame_r;
  logic               ro_r;
  logic [REF_W-1:0]   ref_r;
  logic               rd_r;
  logic               wr_r;
  logic [REF_W-1:0]   rd_next_r;
  logic [FLAGS_W-1:0] rd_flags_r;

  logic               strobe_r;
  logic [1:0]         status_r;
  logic [REF_W-1:0]   gref_r;

  logic [1:0]         status_nxt;
  logic [REF_W-1:0]   gref_nxt;
  logic               flags_we;
  logic [REF_W-1:0]   flags_addr;
  logic [FLAGS_W-1:0] flags_wdata;
  logic               link_we;
  logic [REF_W-1:0]   link_addr;
  logic [REF_W-1:0]   link_wdata;
  logic               entry_we;
  logic               head_usable;
  logic               ref_usable;

  assign stat.sweep_done = (sweep_r == REF_W'(NUM_ENTRIES - 1));

  assign head_usable = (head_r >= REF_W'(NUM_RESERVED));
  assign ref_usable  = (ref_r >= REF_W'(NUM_RESERVED)) &&
                       ({1'b0, ref_r} < (REF_W+1)'(NUM_ENTRIES)) &&
                       rd_flags_r[FL_PERMIT];

  always_comb begin
    head_nxt    = head_r;
    status_nxt  = ST_BADREF;
    gref_nxt    = '0;
    flags_we    = 1'b0;
    flags_addr  = ref_r;
    flags_wdata = '0;
    link_we     = 1'b0;
    link_addr   = ref_r;
    link_wdata  = head_r;
    entry_we    = 1'b0;
    if (cmd.init_wr) begin
      flags_we   = 1'b1;
      flags_addr = sweep_r;
      link_we    = 1'b1;
      link_addr  = sweep_r;
      link_wdata = (sweep_r == '0) ? '0 : sweep_r - REF_W'(1);
    end else if (cmd.exec) begin
      unique case (req_r)
        REQ_GRANT: begin
          if (!head_usable) begin
            status_nxt = ST_EMPTY;
          end else begin
            head_nxt    = rd_next_r;
            flags_we    = 1'b1;
            flags_addr  = head_r;
            flags_wdata = {2'b00, ro_r, 1'b1};
            entry_we    = 1'b1;
            status_nxt  = ST_OK;
            gref_nxt    = head_r;
          end
        end
        REQ_END: begin
          if (ref_usable) begin
            if (rd_flags_r[FL_READING] || rd_flags_r[FL_WRITING]) begin
              status_nxt = ST_BUSY;
            end else begin
              flags_we   = 1'b1;
              link_we    = 1'b1;
              head_nxt   = ref_r;
              status_nxt = ST_OK;
            end
          end
        end
        REQ_PEER: begin
          if (ref_usable) begin
            flags_we    = 1'b1;
            flags_wdata = {wr_r, rd_r, rd_flags_r[FL_RDONLY], rd_flags_r[FL_PERMIT]};
            status_nxt  = ST_OK;
          end
        end
        default: begin
          status_nxt = ST_BADREF;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (flags_we) begin
      flags_mem[flags_addr] <= flags_wdata;
    end
    if (link_we) begin
      next_free_mem[link_addr] <= link_wdata;
    end
    if (entry_we) begin
      entry_mem[head_r] <= {dom_r, frame_r};
    end
    if (cmd.load) begin
      rd_next_r  <= next_free_mem[head_r];
      rd_flags_r <= flags_mem[in_ref_req];
      req_r      <= in_req_type;
      dom_r      <= in_domain_id;
      frame_r    <= in_frame;
      ro_r       <= in_read_only;
      ref_r      <= in_ref_req;
      rd_r       <= in_peer_reading;
      wr_r       <= in_peer_writing;
    end
    status_r <= status_nxt;
    gref_r   <= gref_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r  <= '0;
      head_r   <= REF_W'(NUM_ENTRIES - 1);
      strobe_r <= 1'b0;
    end else begin
      if (cmd.init_wr && !stat.sweep_done) begin
        sweep_r <= sweep_r + REF_W'(1);
      end
      head_r   <= head_nxt;
      strobe_r <= cmd.exec;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_granted_ref = gref_r;

  a_head_moves_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cmd.exec) |-> $stable(head_r))
    else $error("Free-list head changed outside an execution step.");

  a_grant_not_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_granted_ref != '0 |-> out_granted_ref >= REF_W'(NUM_RESERVED)
      && out_status == ST_OK)
    else $error("Reserved reference handed out.");

  a_gref_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != ST_OK |-> out_granted_ref == '0)
    else $error("Reference returned with a failing status.");

endmodule

[hw/rtl/grant_table_allocator.sv]
// Grant table allocator. After reset the block runs a clearing pass over every entry that
// builds the descending free list and clears all entry flags; busy stays high throughout.
// Once idle, an item is taken when start is high and busy is low; a load step reads the
// free-list link and the entry flags from their synchronous memories and an execution step
// updates them. Busy is high in the execution step, so no new item is taken before the last
// one is executed. The result appears on out_status and out_granted_ref for exactly one
// cycle, marked by out_strobe, in the cycle after the execution step. The receiver cannot
// stall the block, so each result transfer must be captured in the cycle it is strobed.
module grant_table_allocator import gta_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [DOM_W-1:0]   in_domain_id,
  input  logic [FRAME_W-1:0] in_frame,
  input  logic               in_read_only,
  input  logic [REF_W-1:0]   in_ref_req,
  input  logic               in_peer_reading,
  input  logic               in_peer_writing,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [REF_W-1:0]   out_granted_ref
);

  gta_cmd_t  cmd;
  gta_stat_t stat;

  gta_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  gta_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_req_type),
    .in_domain_id    (in_domain_id),
    .in_frame        (in_frame),
    .in_read_only    (in_read_only),
    .in_ref_req      (in_ref_req),
    .in_peer_reading (in_peer_reading),
    .in_peer_writing (in_peer_writing),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_granted_ref (out_granted_ref)
  );

endmodule

[test/grant_table_checker.sv]
module grant_table_checker import gta_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       in_req_type,
  input  logic             in_read_only,
  input  logic [REF_W-1:0] in_ref_req,
  input  logic             in_peer_reading,
  input  logic             in_peer_writing,
  input  logic             out_strobe,
  input  logic [1:0]       out_status,
  input  logic [REF_W-1:0] out_granted_ref,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]       status;
    logic [REF_W-1:0] gref;
  } grant_result_t;

  logic [REF_W-1:0]   free_head;
  logic [REF_W-1:0]   free_link [NUM_ENTRIES];
  logic [FLAGS_W-1:0] entry_flags [NUM_ENTRIES];
  grant_result_t      expected_results [$];
  grant_result_t      got;
  grant_result_t      want;
  int                 errors = 0;

  function automatic bit usable(input logic [REF_W-1:0] r);
    return int'(r) >= NUM_RESERVED && int'(r) < NUM_ENTRIES;
  endfunction

  function automatic grant_result_t apply_request(input logic [1:0] req, input logic ro,
                                                  input logic [REF_W-1:0] r,
                                                  input logic rd, input logic wr);
    grant_result_t    res;
    logic [REF_W-1:0] h;
    res.status = ST_BADREF;
    res.gref   = '0;
    case (req)
      REQ_GRANT: begin
        h = free_head;
        if (!usable(h)) begin
          res.status = ST_EMPTY;
        end else begin
          free_head                = free_link[h];
          entry_flags[h]           = '0;
          entry_flags[h][FL_PERMIT] = 1'b1;
          entry_flags[h][FL_RDONLY] = ro;
          res.status               = ST_OK;
          res.gref                 = h;
        end
      end
      REQ_END: begin
        if (usable(r) && entry_flags[r][FL_PERMIT]) begin
          if (entry_flags[r][FL_READING] || entry_flags[r][FL_WRITING]) begin
            res.status = ST_BUSY;
          end else begin
            entry_flags[r] = '0;
            free_link[r]   = free_head;
            free_head      = r;
            res.status     = ST_OK;
          end
        end
      end
      REQ_PEER: begin
        if (usable(r) && entry_flags[r][FL_PERMIT]) begin
          entry_flags[r][FL_READING] = rd;
          entry_flags[r][FL_WRITING] = wr;
          res.status                 = ST_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      free_head = REF_W'(NUM_ENTRIES - 1);
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        free_link[i]   = (i == 0) ? '0 : REF_W'(i - 1);
        entry_flags[i] = '0;
      end
      expected_results.delete();
    end else begin
      // A result transfer always belongs to an item accepted at an earlier edge.
      if (out_strobe) begin
        got.status = out_status;
        got.gref   = out_granted_ref;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result transfer: status %0d ref %0d",
                     $realtime, got.status, got.gref);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.gref !== want.gref) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: status exp %0d got %0d, ref exp %0d got %0d",
                       $realtime, want.status, got.status, want.gref, got.gref);
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_request(in_req_type, in_read_only, in_ref_req,
                                                 in_peer_reading, in_peer_writing));
    end
    outstanding <= expected_results.size();
    mismatches  <= errors;
  end

endmodule

[test/grant_table_allocator_test.sv]
module grant_table_allocator_test import gta_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]       REQ_UNKNOWN    = 2'd3;
  localparam logic [REF_W-1:0] TOP_REF        = REF_W'(NUM_ENTRIES - 1);
  localparam int               RANDOM_ITEMS   = 1120;
  localparam int               WATCHDOG_LIMIT = 10000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_req_type = REQ_GRANT;
  logic [DOM_W-1:0]   in_domain_id = '0;
  logic [FRAME_W-1:0] in_frame = '0;
  logic               in_read_only = 1'b0;
  logic [REF_W-1:0]   in_ref_req = '0;
  logic               in_peer_reading = 1'b0;
  logic               in_peer_writing = 1'b0;
  logic               out_strobe;
  logic [1:0]         out_status;
  logic [REF_W-1:0]   out_granted_ref;
  int                 mismatches;
  int                 outstanding;

  logic [REF_W-1:0]   granted_refs [$];
  bit                 marked [NUM_ENTRIES];
  int                 stall_cycles = 0;

  grant_table_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_domain_id    (in_domain_id),
    .in_frame        (in_frame),
    .in_read_only    (in_read_only),
    .in_ref_req      (in_ref_req),
    .in_peer_reading (in_peer_reading),
    .in_peer_writing (in_peer_writing),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_granted_ref (out_granted_ref)
  );

  grant_table_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_read_only    (in_read_only),
    .in_ref_req      (in_ref_req),
    .in_peer_reading (in_peer_reading),
    .in_peer_writing (in_peer_writing),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_granted_ref (out_granted_ref),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Granted references are learnt from the results, away from the rising edge.
  always @(negedge clk) begin
    if (rst_n && out_strobe) begin
      if (out_status == ST_OK && out_granted_ref != '0) begin
        granted_refs.push_back(out_granted_ref);
        marked[out_granted_ref] = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic issue(input logic [1:0] req, input logic [DOM_W-1:0] dom,
                       input logic [FRAME_W-1:0] frm, input logic ro,
                       input logic [REF_W-1:0] r, input logic rd, input logic wr);
    start           <= 1'b1;
    in_req_type     <= req;
    in_domain_id    <= dom;
    in_frame        <= frm;
    in_read_only    <= ro;
    in_ref_req      <= r;
    in_peer_reading <= rd;
    in_peer_writing <= wr;
    do @(posedge clk); while (busy);
  endtask

  task automatic grant_req(input logic [DOM_W-1:0] dom, input logic [FRAME_W-1:0] frm,
                           input logic ro);
    issue(REQ_GRANT, dom, frm, ro, REF_W'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic end_req(input logic [REF_W-1:0] r);
    issue(REQ_END, DOM_W'($urandom), $urandom, 1'($urandom), r, 1'($urandom), 1'($urandom));
  endtask

  task automatic peer_req(input logic [REF_W-1:0] r, input logic rd, input logic wr);
    issue(REQ_PEER, DOM_W'($urandom), $urandom, 1'($urandom), r, rd, wr);
    marked[r] = rd | wr;
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic random_gap(inout int burst_left);
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) != 0)
        pause($urandom_range(1, 12));
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  initial begin
    int burst_left;
    int pick;
    int idx;
    logic [REF_W-1:0] r;
    logic rd;
    logic wr;

    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    grant_req('0, '0, 1'b0);
    grant_req('1, '1, 1'b1);
    peer_req(TOP_REF, 1'b1, 1'b0);
    end_req(TOP_REF);
    peer_req(TOP_REF, 1'b0, 1'b1);
    end_req(TOP_REF);
    peer_req(TOP_REF, 1'b1, 1'b1);
    peer_req(TOP_REF, 1'b0, 1'b0);
    end_req(TOP_REF);
    end_req(TOP_REF);
    peer_req(TOP_REF, 1'b1, 1'b1);
    end_req('0);
    peer_req(REF_W'(NUM_RESERVED - 1), 1'b1, 1'b1);
    end_req(REF_W'(NUM_RESERVED));
    end_req(TOP_REF - REF_W'(2));
    issue(REQ_UNKNOWN, '1, '1, 1'b1, '1, 1'b1, 1'b1);
    grant_req(DOM_W'($urandom), $urandom, 1'b0);
    peer_req(TOP_REF - REF_W'(1), 1'b1, 1'b1);
    end_req(TOP_REF - REF_W'(1));
    peer_req(TOP_REF - REF_W'(1), 1'b0, 1'b0);
    end_req(TOP_REF - REF_W'(1));
    end_req(TOP_REF);
    drain();
    granted_refs.delete();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      random_gap(burst_left);
      pick = $urandom_range(0, 99);
      if (pick >= 30 && pick < 82 && granted_refs.size() == 0)
        pick = 0;
      if (pick < 30) begin
        grant_req(DOM_W'($urandom), $urandom, 1'($urandom));
      end else if (pick < 60) begin
        idx = $urandom_range(0, granted_refs.size() - 1);
        r = granted_refs[idx];
        if (!marked[r])
          granted_refs.delete(idx);
        end_req(r);
      end else if (pick < 82) begin
        r = granted_refs[$urandom_range(0, granted_refs.size() - 1)];
        if ($urandom_range(0, 1) == 0) begin
          rd = 1'b0;
          wr = 1'b0;
        end else begin
          rd = 1'($urandom);
          wr = 1'($urandom);
        end
        peer_req(r, rd, wr);
      end else begin
        if ($urandom_range(0, 1) == 0)
          r = REF_W'($urandom_range(0, NUM_RESERVED - 1));
        else
          r = REF_W'($urandom_range(0, NUM_ENTRIES - 1));
        rd = 1'($urandom);
        wr = 1'($urandom);
        issue(2'($urandom), DOM_W'($urandom), $urandom, 1'($urandom), r, rd, wr);
        if (in_req_type == REQ_PEER)
          marked[r] = rd | wr;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/gta_pkg.sv
hw/rtl/gta_ctrl.sv
hw/rtl/gta_dp.sv
hw/rtl/grant_table_allocator.sv
test/grant_table_checker.sv
test/grant_table_allocator_test.sv
